// ===== hw/rtl/sa_pkg.sv =====
// shared types, constants and codes for the shelf atlas allocator
// no dependencies; used by sa_cell and shelf_atlas_allocator_top
package sa_pkg;

    localparam int MAX_SIZE    = 4096;
    localparam int MAX_SHELVES = 64;
    localparam int IDX_W       = $clog2(MAX_SHELVES);
    localparam int DIM_W       = 13;
    localparam int POS_W       = 12;

    localparam logic [2:0] ST_PLACED  = 3'd0;
    localparam logic [2:0] ST_BAD     = 3'd1;
    localparam logic [2:0] ST_NOSPACE = 3'd2;
    localparam logic [2:0] ST_TABLE   = 3'd3;
    localparam logic [2:0] ST_CLEARED = 3'd4;

    localparam logic [2:0] CH_ICON = 3'd4;

    localparam logic [1:0] ACT_GLYPH     = 2'd0;
    localparam logic [1:0] ACT_ICON      = 2'd1;
    localparam logic [1:0] ACT_CLR_GLYPH = 2'd2;
    localparam logic [1:0] ACT_CLR_ICON  = 2'd3;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DECIDE,
        S_OUT
    } state_t;

    // token that sweeps down the row of shelf cells
    typedef struct packed {
        logic             live;
        logic             found;
        logic [POS_W-1:0] x;
        logic [DIM_W-1:0] top;
        logic [1:0]       ch;
        logic             free;
        logic [IDX_W-1:0] idx;
    } sweep_t;

    // request held steady during a sweep
    typedef struct packed {
        logic             icon;
        logic [DIM_W-1:0] w;
        logic [DIM_W-1:0] desired;
        logic [DIM_W-1:0] atlas;
    } req_t;

    // broadcast control to all cells
    typedef struct packed {
        logic             clr_glyph;
        logic             clr_icon;
        logic             wr_en;
        logic [IDX_W-1:0] wr_idx;
        logic             wr_icon;
        logic [1:0]       wr_ch;
        logic [DIM_W-1:0] wr_height;
        logic [DIM_W-1:0] wr_top;
        logic [DIM_W-1:0] wr_fill;
        logic             wr_full;
    } cell_ctl_t;

endpackage

// ===== hw/rtl/sa_cell.sv =====
// one shelf table entry; checks the passing sweep token and forwards it
// depends on sa_pkg
module sa_cell
    import sa_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic [IDX_W-1:0] cell_idx,
    input  req_t             req,
    input  cell_ctl_t        ctl,
    input  sweep_t           sweep_in,
    output sweep_t           sweep_out
);

    logic             valid_reg;
    logic             full_reg;
    logic             icon_reg;
    logic [1:0]       ch_reg;
    logic [DIM_W-1:0] height_reg;
    logic [DIM_W-1:0] top_reg;
    logic [DIM_W-1:0] fill_reg;
    sweep_t           sweep_reg;
    sweep_t           sweep_next;

    logic [DIM_W:0] sum;
    logic           hit;
    logic           clr_hit;

    assign sum = {1'b0, fill_reg} + {1'b0, req.w};
    assign hit = sweep_in.live && !sweep_in.found && valid_reg && !full_reg
                 && (icon_reg == req.icon) && (height_reg == req.desired)
                 && (sum <= {1'b0, req.atlas});
    assign clr_hit = valid_reg && ((ctl.clr_glyph && !icon_reg) || (ctl.clr_icon && icon_reg));

    always_comb begin
        sweep_next = sweep_in;
        if (hit) begin
            sweep_next.found = 1'b1;
            sweep_next.x     = fill_reg[POS_W-1:0];
            sweep_next.top   = top_reg;
            sweep_next.ch    = ch_reg;
        end
        if (sweep_in.live && !sweep_in.free && !valid_reg) begin
            sweep_next.free = 1'b1;
            sweep_next.idx  = cell_idx;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sweep_reg <= '0;
        end else begin
            sweep_reg <= sweep_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            full_reg  <= 1'b0;
        end else if (ctl.wr_en && ctl.wr_idx == cell_idx) begin
            valid_reg <= 1'b1;
            full_reg  <= ctl.wr_full;
        end else if (clr_hit) begin
            valid_reg <= 1'b0;
            full_reg  <= 1'b0;
        end else if (hit) begin
            full_reg <= (sum == {1'b0, req.atlas});
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.wr_en && ctl.wr_idx == cell_idx) begin
            icon_reg   <= ctl.wr_icon;
            ch_reg     <= ctl.wr_ch;
            height_reg <= ctl.wr_height;
            top_reg    <= ctl.wr_top;
            fill_reg   <= ctl.wr_fill;
        end else if (hit) begin
            fill_reg <= sum[DIM_W-1:0];
        end
    end

    assign sweep_out = sweep_reg;

endmodule

// ===== hw/rtl/shelf_atlas_allocator_top.sv =====
// top level of the shelf atlas allocator: sequencer plus row of shelf cells
// depends on sa_pkg and sa_cell
//
// usage:
//   requests come in on the s_ stream: s_tuser carries the action (place
//   glyph, place icon, clear glyph area, clear icon area), s_tdata the
//   rectangle width and height. every request gives exactly one result
//   transfer on the m_ stream: status, x, y and channel.
//   the atlas side length is written on the cfg_ channel while idle; a
//   write saturates at 4096 and clears both areas.
// timing:
//   a placement registers the request and launches a token into the first
//   of the 64 shelf cells; the token passes one cell per cycle, then the
//   sequencer takes a decision step and moves the result to the output
//   register, after which the next request is taken. clears and rejected
//   requests go from accept straight to the output step. one request is in
//   flight at a time.
// reset:
//   aresetn clears all shelves, sets the atlas size to 1024 and leaves the
//   output empty.
// stall:
//   a result waits in the output register while m_tready is low; the next
//   request is taken while it waits, and its own result holds until the
//   output register is free again.
module shelf_atlas_allocator_top
    import sa_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // rect_width[12:0], rect_height[25:13], zero pad
    input  logic [1:0]  s_tuser,   // action[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // status[2:0], place_x[14:3], place_y[26:15],
                                   // channel[29:27], zero pad
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data   // atlas_size[12:0], upper bits ignored
);

    state_t           state_reg, state_next;
    logic [DIM_W-1:0] atlas_reg, atlas_next;
    logic [DIM_W-1:0] floor_reg, floor_next;
    logic [DIM_W-1:0] gtop_reg [4];
    logic [DIM_W-1:0] gtop_next [4];
    req_t             req_reg, req_next;
    sweep_t           tail_reg, tail_next;
    logic [2:0]       rs_reg, rs_next;
    logic [POS_W-1:0] rx_reg, rx_next;
    logic [POS_W-1:0] ry_reg, ry_next;
    logic [2:0]       rc_reg, rc_next;
    logic             mv_reg, mv_next;
    logic [29:0]      md_reg, md_next;
    logic             launch_reg, launch_next;

    cell_ctl_t ctl;
    sweep_t    chain [MAX_SHELVES+1];

    logic             s_acc, cfg_acc;
    logic [DIM_W-1:0] in_w, in_h;
    logic [DIM_W:0]   h_round;
    logic [DIM_W-1:0] desired;
    logic             bad;
    logic [13:0]      cfg_sat;

    // new shelf candidates
    logic [1:0]       gch;
    logic [DIM_W-1:0] gtop_min;
    logic [DIM_W:0]   gsum;
    logic [DIM_W-1:0] itop;
    logic             ifit;

    assign s_tready  = (state_reg == S_IDLE) && !cfg_valid;
    assign cfg_ready = (state_reg == S_IDLE);
    assign s_acc     = s_tvalid && s_tready;
    assign cfg_acc   = cfg_valid && cfg_ready;

    assign in_w    = s_tdata[12:0];
    assign in_h    = s_tdata[25:13];
    assign h_round = {1'b0, in_h} + 14'd3;
    assign desired = {h_round[DIM_W-1:2], 2'b00};
    assign bad     = (in_w == '0) || (in_h == '0) || (in_w > atlas_reg) || (in_h > atlas_reg);
    assign cfg_sat = ({1'b0, cfg_data[12:0]} > 14'(MAX_SIZE)) ? 14'(MAX_SIZE)
                                                             : {1'b0, cfg_data[12:0]};

    // lowest glyph channel, lowest index on ties
    always_comb begin
        gch      = 2'd0;
        gtop_min = gtop_reg[0];
        for (int i = 1; i < 4; i++) begin
            if (gtop_reg[i] < gtop_min) begin
                gch      = 2'(i);
                gtop_min = gtop_reg[i];
            end
        end
    end
    assign gsum = {1'b0, gtop_min} + {1'b0, req_reg.desired};
    assign itop = floor_reg - req_reg.desired;
    always_comb begin
        ifit = (floor_reg >= req_reg.desired);
        for (int i = 0; i < 4; i++) begin
            if (itop < gtop_reg[i]) ifit = 1'b0;
        end
    end

    // sweep launch enters the first cell once the request register holds it
    assign launch_next = s_acc && !bad && (s_tuser == ACT_GLYPH || s_tuser == ACT_ICON);
    always_comb begin
        chain[0]      = '0;
        chain[0].live = launch_reg;
    end

    for (genvar g = 0; g < MAX_SHELVES; g++) begin : g_cell
        sa_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .cell_idx  (IDX_W'(g)),
            .req       (req_reg),
            .ctl       (ctl),
            .sweep_in  (chain[g]),
            .sweep_out (chain[g+1])
        );
    end

    always_comb begin
        state_next = state_reg;
        atlas_next = atlas_reg;
        floor_next = floor_reg;
        gtop_next  = gtop_reg;
        req_next   = req_reg;
        tail_next  = tail_reg;
        rs_next    = rs_reg;
        rx_next    = rx_reg;
        ry_next    = ry_reg;
        rc_next    = rc_reg;
        mv_next    = mv_reg;
        md_next    = md_reg;
        ctl        = '0;

        // output register drains independently
        if (mv_reg && m_tready) mv_next = 1'b0;

        case (state_reg)
            S_IDLE: begin
                if (cfg_acc) begin
                    // new atlas: both areas start empty
                    atlas_next    = cfg_sat[DIM_W-1:0];
                    floor_next    = cfg_sat[DIM_W-1:0];
                    ctl.clr_glyph = 1'b1;
                    ctl.clr_icon  = 1'b1;
                    for (int i = 0; i < 4; i++) gtop_next[i] = '0;
                end else if (s_acc) begin
                    rx_next = '0;
                    ry_next = '0;
                    rc_next = '0;
                    case (s_tuser)
                        ACT_CLR_GLYPH: begin
                            ctl.clr_glyph = 1'b1;
                            for (int i = 0; i < 4; i++) gtop_next[i] = '0;
                            rs_next    = ST_CLEARED;
                            state_next = S_OUT;
                        end
                        ACT_CLR_ICON: begin
                            ctl.clr_icon = 1'b1;
                            floor_next   = atlas_reg;
                            rs_next      = ST_CLEARED;
                            state_next   = S_OUT;
                        end
                        default: begin
                            if (bad) begin
                                rs_next    = ST_BAD;
                                state_next = S_OUT;
                            end else begin
                                req_next.icon    = (s_tuser == ACT_ICON);
                                req_next.w       = in_w;
                                req_next.desired = desired;
                                req_next.atlas   = atlas_reg;
                                state_next       = S_SCAN;
                            end
                        end
                    endcase
                end
            end
            S_SCAN: begin
                if (chain[MAX_SHELVES].live) begin
                    tail_next  = chain[MAX_SHELVES];
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE: begin
                state_next = S_OUT;
                rx_next    = '0;
                ry_next    = '0;
                rc_next    = '0;
                if (tail_reg.found) begin
                    rs_next = ST_PLACED;
                    rx_next = tail_reg.x;
                    ry_next = tail_reg.top[POS_W-1:0];
                    rc_next = req_reg.icon ? CH_ICON : {1'b0, tail_reg.ch};
                end else if (req_reg.icon ? !ifit : (gsum > {1'b0, floor_reg})) begin
                    rs_next = ST_NOSPACE;
                end else if (!tail_reg.free) begin
                    rs_next = ST_TABLE;
                end else begin
                    rs_next       = ST_PLACED;
                    ctl.wr_en     = 1'b1;
                    ctl.wr_idx    = tail_reg.idx;
                    ctl.wr_icon   = req_reg.icon;
                    ctl.wr_height = req_reg.desired;
                    ctl.wr_fill   = req_reg.w;
                    ctl.wr_full   = (req_reg.w == req_reg.atlas);
                    if (req_reg.icon) begin
                        floor_next  = itop;
                        ctl.wr_ch   = 2'd0;
                        ctl.wr_top  = itop;
                        ry_next     = itop[POS_W-1:0];
                        rc_next     = CH_ICON;
                    end else begin
                        gtop_next[gch] = gsum[DIM_W-1:0];
                        ctl.wr_ch      = gch;
                        ctl.wr_top     = gtop_min;
                        ry_next        = gtop_min[POS_W-1:0];
                        rc_next        = {1'b0, gch};
                    end
                end
            end
            S_OUT: begin
                if (!mv_reg || m_tready) begin
                    mv_next    = 1'b1;
                    md_next    = {rc_reg, ry_reg, rx_reg, rs_reg};
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            atlas_reg  <= DIM_W'(1024);
            floor_reg  <= DIM_W'(1024);
            for (int i = 0; i < 4; i++) gtop_reg[i] <= '0;
            mv_reg     <= 1'b0;
            launch_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            atlas_reg  <= atlas_next;
            floor_reg  <= floor_next;
            gtop_reg   <= gtop_next;
            mv_reg     <= mv_next;
            launch_reg <= launch_next;
        end
    end

    always_ff @(posedge aclk) begin
        req_reg  <= req_next;
        tail_reg <= tail_next;
        rs_reg   <= rs_next;
        rx_reg   <= rx_next;
        ry_reg   <= ry_next;
        rc_reg   <= rc_next;
        md_reg   <= md_next;
    end

    assign m_tvalid = mv_reg;
    assign m_tdata  = {2'b00, md_reg};

    // the sweep token reaches the end of the row only during a scan
    a_tail_in_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        chain[MAX_SHELVES].live |-> state_reg == S_SCAN)
        else $error("sweep token left the row outside a scan");

    // a decision always hands over to the output step
    a_decide_out: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_DECIDE |=> state_reg == S_OUT)
        else $error("decision did not lead to output");

    // shelves open only from the decision step, into a free entry
    a_write_decide: assert property (@(posedge aclk) disable iff (!aresetn)
        ctl.wr_en |-> (state_reg == S_DECIDE && tail_reg.free && !tail_reg.found))
        else $error("shelf opened outside a decision");

    // the atlas size register never exceeds the largest supported side
    a_atlas_range: assert property (@(posedge aclk) disable iff (!aresetn)
        atlas_reg <= DIM_W'(MAX_SIZE))
        else $error("atlas size out of range");

endmodule
